// ===== sv/dpsa_pkg.sv =====
// Shared constants, codes and types of the dense pool slot allocator.
package dpsa_pkg;

	// Pool geometry
	localparam int POOL_SIZE = 256;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	// Port field widths
	localparam int OPC_W   = 2;
	localparam int POS_W   = 8;
	localparam int HDL_W   = 8;
	localparam int GRANT_W = 8;
	localparam int ST_W    = 2;
	localparam int LIVE_W  = 9;

	// Width that holds a count, a position, a handle or a table entry
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Operation codes
	localparam logic [OPC_W-1:0] OP_ALLOC       = 2'd0;
	localparam logic [OPC_W-1:0] OP_FREE_POS    = 2'd1;
	localparam logic [OPC_W-1:0] OP_FREE_HANDLE = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_POS  = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_LIVE = 2'd3;

	// Slot table access request from the sequencer
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr_a;
		logic [IDX_W-1:0] rd_addr_b;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] wr_data;
	} ram_req_t;

	// One result item
	typedef struct packed {
		logic [GRANT_W-1:0] granted;
		logic [ST_W-1:0]    status;
		logic [LIVE_W-1:0]  live;
	} result_t;

endpackage

// ===== sv/dpsa_slot_ram.sv =====
// Slot table memory: one write port, two registered read ports, identity reset map.
module dpsa_slot_ram (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dpsa_pkg::ram_req_t      req,
	output logic [dpsa_pkg::IDX_W-1:0] rd_data_a,
	output logic [dpsa_pkg::IDX_W-1:0] rd_data_b
);

	logic [dpsa_pkg::IDX_W-1:0]     mem [dpsa_pkg::POOL_SIZE];
	logic [dpsa_pkg::POOL_SIZE-1:0] written_q;
	logic [dpsa_pkg::IDX_W-1:0]     mem_a_q;
	logic [dpsa_pkg::IDX_W-1:0]     mem_b_q;
	logic [dpsa_pkg::IDX_W-1:0]     addr_a_q;
	logic [dpsa_pkg::IDX_W-1:0]     addr_b_q;
	logic                           vld_a_q;
	logic                           vld_b_q;

	// Write port and registered reads
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_a_q  <= mem[req.rd_addr_a];
			mem_b_q  <= mem[req.rd_addr_b];
			addr_a_q <= req.rd_addr_a;
			addr_b_q <= req.rd_addr_b;
			vld_a_q  <= written_q[req.rd_addr_a];
			vld_b_q  <= written_q[req.rd_addr_b];
		end
	end

	// Track entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (req.wr_en) begin
			written_q[req.wr_addr] <= 1'b1;
		end
	end

	// An entry never written holds its own index
	assign rd_data_a = vld_a_q ? mem_a_q : addr_a_q;
	assign rd_data_b = vld_b_q ? mem_b_q : addr_b_q;

endmodule

// ===== sv/dpsa_ctrl.sv =====
// Operation sequencer: live count, table read-modify-write and handle search.
module dpsa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dpsa_pkg::OPC_W-1:0]    opcode,
	input  logic [dpsa_pkg::POS_W-1:0]    position,
	input  logic [dpsa_pkg::HDL_W-1:0]    handle,
	output dpsa_pkg::ram_req_t            ram_req,
	input  logic [dpsa_pkg::IDX_W-1:0]    rd_data_a,
	input  logic [dpsa_pkg::IDX_W-1:0]    rd_data_b,
	input  logic                          out_free,
	output logic                          res_load,
	output dpsa_pkg::result_t             res
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_SWAP   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0]                    state_q, state_d;
	logic [dpsa_pkg::CNT_W-1:0]    count_q, count_d;
	logic [dpsa_pkg::IDX_W-1:0]    idx_q, idx_d;
	logic [dpsa_pkg::IDX_W-1:0]    pos_q, pos_d;
	logic [dpsa_pkg::HDL_W-1:0]    hdl_q, hdl_d;
	logic [dpsa_pkg::IDX_W-1:0]    held_q, held_d;
	logic [dpsa_pkg::ST_W-1:0]     status_q, status_d;
	logic [dpsa_pkg::IDX_W-1:0]    last_idx;
	logic                          pos_ok;
	logic                          not_full;
	logic                          hit;

	assign last_idx = dpsa_pkg::IDX_W'(count_q - dpsa_pkg::CNT_W'(1));
	assign pos_ok   = dpsa_pkg::CMP_W'(position) < dpsa_pkg::CMP_W'(count_q);
	assign not_full = count_q < dpsa_pkg::CNT_W'(dpsa_pkg::POOL_SIZE);
	assign hit      = dpsa_pkg::CMP_W'(rd_data_a) == dpsa_pkg::CMP_W'(hdl_q);
	assign in_ready = (state_q == S_IDLE);

	// Sequence one operation at a time; reads and writes never overlap on the table
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		hdl_d    = hdl_q;
		held_d   = held_q;
		status_d = status_q;
		ram_req  = '0;
		res_load = 1'b0;
		res      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						dpsa_pkg::OP_ALLOC: begin
							if (not_full) begin
								ram_req.rd_en     = 1'b1;
								ram_req.rd_addr_a = dpsa_pkg::IDX_W'(count_q);
								ram_req.rd_addr_b = dpsa_pkg::IDX_W'(count_q);
								state_d           = S_ALLOC;
							end else begin
								status_d = dpsa_pkg::ST_FULL;
								state_d  = S_RESP;
							end
						end
						dpsa_pkg::OP_FREE_POS: begin
							if (pos_ok) begin
								ram_req.rd_en     = 1'b1;
								ram_req.rd_addr_a = dpsa_pkg::IDX_W'(position);
								ram_req.rd_addr_b = last_idx;
								pos_d             = dpsa_pkg::IDX_W'(position);
								state_d           = S_SWAP;
							end else begin
								status_d = dpsa_pkg::ST_BAD_POS;
								state_d  = S_RESP;
							end
						end
						dpsa_pkg::OP_FREE_HANDLE: begin
							if (count_q != '0) begin
								ram_req.rd_en     = 1'b1;
								ram_req.rd_addr_a = last_idx;
								ram_req.rd_addr_b = last_idx;
								idx_d             = last_idx;
								hdl_d             = handle;
								state_d           = S_SEARCH;
							end else begin
								status_d = dpsa_pkg::ST_NOT_LIVE;
								state_d  = S_RESP;
							end
						end
						default: begin
							status_d = dpsa_pkg::ST_OK;
							state_d  = S_RESP;
						end
					endcase
				end
			end
			S_ALLOC: begin
				if (out_free) begin
					res_load    = 1'b1;
					res.granted = dpsa_pkg::GRANT_W'(rd_data_a);
					res.status  = dpsa_pkg::ST_OK;
					res.live    = dpsa_pkg::LIVE_W'(count_q + dpsa_pkg::CNT_W'(1));
					count_d     = count_q + dpsa_pkg::CNT_W'(1);
					state_d     = S_IDLE;
				end
			end
			S_SEARCH: begin
				// Walk down from the top live entry; port B keeps the last entry
				if (hit) begin
					pos_d   = idx_q;
					state_d = S_SWAP;
				end else if (idx_q == '0) begin
					status_d = dpsa_pkg::ST_NOT_LIVE;
					state_d  = S_RESP;
				end else begin
					ram_req.rd_en     = 1'b1;
					ram_req.rd_addr_a = idx_q - dpsa_pkg::IDX_W'(1);
					ram_req.rd_addr_b = last_idx;
					idx_d             = idx_q - dpsa_pkg::IDX_W'(1);
				end
			end
			S_SWAP: begin
				// Move the last live handle into the freed position
				held_d          = rd_data_a;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = pos_q;
				ram_req.wr_data = rd_data_b;
				state_d         = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = last_idx;
					ram_req.wr_data = held_q;
					res_load        = 1'b1;
					res.status      = dpsa_pkg::ST_OK;
					res.live        = dpsa_pkg::LIVE_W'(count_q - dpsa_pkg::CNT_W'(1));
					count_d         = count_q - dpsa_pkg::CNT_W'(1);
					state_d         = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					res_load   = 1'b1;
					res.status = status_q;
					res.live   = dpsa_pkg::LIVE_W'(count_q);
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Operation operands
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		hdl_q    <= hdl_d;
		held_q   <= held_d;
		status_q <= status_d;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dpsa_pkg::CNT_W'(dpsa_pkg::POOL_SIZE))
		else $error("live count above pool size");
	a_count_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!res_load |=> count_q == $past(count_q))
		else $error("live count changed without a result");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.status == dpsa_pkg::ST_FULL) |->
		count_q == dpsa_pkg::CNT_W'(dpsa_pkg::POOL_SIZE))
		else $error("full reported with free slots");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en |-> (state_q == S_SWAP || state_q == S_FIN))
		else $error("table write outside swap");
	a_search_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> dpsa_pkg::CMP_W'(idx_q) < dpsa_pkg::CMP_W'(count_q))
		else $error("search index beyond live entries");
`endif

endmodule

// ===== sv/dpsa_out_reg.sv =====
// Output register of the result channel.
module dpsa_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  dpsa_pkg::result_t               res,
	output logic                            out_free,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dpsa_pkg::GRANT_W-1:0]    granted_handle,
	output logic [dpsa_pkg::ST_W-1:0]       status,
	output logic [dpsa_pkg::LIVE_W-1:0]     live_after
);

	logic              valid_q;
	dpsa_pkg::result_t res_q;

	// Slot is free when empty or when its result transfers this cycle
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// Hold the payload until it transfers
	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign granted_handle = res_q.granted;
	assign status         = res_q.status;
	assign live_after     = res_q.live;

endmodule

// ===== sv/dense_pool_slot_allocator.sv =====
// Dense pool slot allocator: 256 handles kept as a permutation table with a live count.
//
// Input channel (in_valid/in_ready) takes opcode, position and handle; the
// result channel (out_valid/out_ready) returns granted_handle, status and
// live_after, one result per input in order. in_ready is high whenever the
// sequencer is idle, also while a result waits in the output register.
// Steps from the input transfer until the result is loaded: allocate reads
//   the entry at the live count; free by position reads that position and
//   the last live entry, then writes the two swapped; free by handle walks
//   down from the top live entry to the match, then swaps like a position;
//   a miss, rejected operations and the unused opcode load a status only.
// The next input is taken the cycle after the result is loaded, so an
// allocate stream takes a new item only once the previous one is done. The
// registered read of the slot table and its single write port (a free needs
// two writes) bound the stream; the handle search reads one entry per cycle.
// Reset (arst_n low) empties the pool: live count zero, entry i holds
// handle i via per-entry written flags, no clearing pass needed.
// When a result waits in the output register and out_ready is low, a
// finished operation holds in the sequencer until it frees up; no result is dropped.
module dense_pool_slot_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dpsa_pkg::OPC_W-1:0]      opcode,
	input  logic [dpsa_pkg::POS_W-1:0]      position,
	input  logic [dpsa_pkg::HDL_W-1:0]      handle,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dpsa_pkg::GRANT_W-1:0]    granted_handle,
	output logic [dpsa_pkg::ST_W-1:0]       status,
	output logic [dpsa_pkg::LIVE_W-1:0]     live_after
);

	dpsa_pkg::ram_req_t            ram_req;
	logic [dpsa_pkg::IDX_W-1:0]    rd_data_a;
	logic [dpsa_pkg::IDX_W-1:0]    rd_data_b;
	logic                          out_free;
	logic                          res_load;
	dpsa_pkg::result_t             res;

	dpsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.position  (position),
		.handle    (handle),
		.ram_req   (ram_req),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	dpsa_slot_ram u_ram (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ram_req),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	dpsa_out_reg u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (res_load),
		.res            (res),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_handle (granted_handle),
		.status         (status),
		.live_after     (live_after)
	);

endmodule

// ===== tb/sv/pool_checker.sv =====
// Checker for the dense pool slot allocator: predicts each transfer and compares results.
`timescale 1ns / 1ps

module pool_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [dpsa_pkg::OPC_W-1:0]   opcode,
	input  logic [dpsa_pkg::POS_W-1:0]   position,
	input  logic [dpsa_pkg::HDL_W-1:0]   handle,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [dpsa_pkg::GRANT_W-1:0] granted_handle,
	input  logic [dpsa_pkg::ST_W-1:0]    status,
	input  logic [dpsa_pkg::LIVE_W-1:0]  live_after,
	output int                           mismatches,
	output int                           outstanding,
	output int                           results_seen,
	output int                           full_seen
);
	import dpsa_pkg::*;

	// Predicted pool: handle permutation and number of handles in use
	logic [HDL_W-1:0] slot_order [POOL_SIZE];
	logic [CNT_W-1:0] live_slots;
	result_t          owed_results [$];
	result_t          oldest;

	// Print one mismatch line and count it
	task automatic log_mismatch(input string what, input int got, input int want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Swap the entry at idx with the last live entry and shrink the live range
	function automatic void release_slot(input int idx);
		logic [HDL_W-1:0] held;
		held = slot_order[idx];
		live_slots = live_slots - 1'b1;
		slot_order[idx] = slot_order[live_slots];
		slot_order[live_slots] = held;
	endfunction

	// Apply one operation to the predicted pool and return its result
	function automatic result_t apply_pool_op(
		input logic [OPC_W-1:0] opc,
		input logic [POS_W-1:0] pos,
		input logic [HDL_W-1:0] hdl
	);
		result_t r;
		int      idx;
		bit      hit;
		r.granted = '0;
		r.status  = ST_OK;
		hit       = 1'b0;
		case (opc)
			OP_ALLOC: begin
				if (live_slots < POOL_SIZE) begin
					r.granted  = slot_order[live_slots];
					live_slots = live_slots + 1'b1;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_FREE_POS: begin
				if (pos < live_slots) begin
					release_slot(int'(pos));
				end else begin
					r.status = ST_BAD_POS;
				end
			end
			OP_FREE_HANDLE: begin
				// search the live entries from the top down
				idx = int'(live_slots);
				while (idx > 0 && !hit) begin
					idx--;
					if (slot_order[idx] == hdl) begin
						hit = 1'b1;
					end
				end
				if (hit) begin
					release_slot(idx);
				end else begin
					r.status = ST_NOT_LIVE;
				end
			end
			default: begin
				// unused opcode leaves the pool alone
			end
		endcase
		r.live = LIVE_W'(live_slots);
		return r;
	endfunction

	// Predict on each input transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				slot_order[i] = HDL_W'(i);
			end
			live_slots = '0;
			owed_results.delete();
			mismatches   = 0;
			outstanding  = 0;
			results_seen = 0;
			full_seen    = 0;
		end else begin
			if (in_valid && in_ready) begin
				owed_results.push_back(apply_pool_op(opcode, position, handle));
			end
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					log_mismatch("result with nothing pending, live_after", int'(live_after), -1);
				end else begin
					oldest = owed_results.pop_front();
					results_seen++;
					if (oldest.status == ST_FULL) begin
						full_seen++;
					end
					if (granted_handle !== oldest.granted) begin
						log_mismatch("granted_handle", int'(granted_handle), int'(oldest.granted));
					end
					if (status !== oldest.status) begin
						log_mismatch("status", int'(status), int'(oldest.status));
					end
					if (live_after !== oldest.live) begin
						log_mismatch("live_after", int'(live_after), int'(oldest.live));
					end
				end
			end
			outstanding = owed_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the slot allocator testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;
	import dpsa_pkg::*;

	localparam logic [OPC_W-1:0] OP_RESERVED = 2'd3;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int HOLD_CYCLES      = 120;
	localparam int SETTLE_CYCLES    = 300;
	localparam int CYCLE_LIMIT      = 1_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [OPC_W-1:0]   opcode;
	logic [POS_W-1:0]   position;
	logic [HDL_W-1:0]   handle;
	logic               out_valid;
	logic               out_ready;
	logic [GRANT_W-1:0] granted_handle;
	logic [ST_W-1:0]    status;
	logic [LIVE_W-1:0]  live_after;

	int mismatches;
	int outstanding;
	int results_seen;
	int full_seen;
	int tx_idle_pct   = 13;
	int rx_idle_pct   = 85;
	bit pressure_on   = 1'b0;
	int ops_sent      = 0;
	int cycle_count   = 0;

	dense_pool_slot_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.position       (position),
		.handle         (handle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_handle (granted_handle),
		.status         (status),
		.live_after     (live_after)
	);

	pool_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.position       (position),
		.handle         (handle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_handle (granted_handle),
		.status         (status),
		.live_after     (live_after),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.full_seen      (full_seen)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dense_pool_slot_allocator test failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when pressure starts
	initial begin
		bit held_off;
		held_off  = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && !held_off) begin
				held_off  = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offer one operation at the falling edge and hold it until the transfer
	task automatic send_op(
		input logic [OPC_W-1:0] op,
		input logic [POS_W-1:0] pos,
		input logic [HDL_W-1:0] hdl
	);
		bit taken;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode   = op;
		position = pos;
		handle   = hdl;
		taken    = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ready;
		end
		ops_sent++;
		@(negedge clk);
	endtask

	// Stimulus and verdict
	initial begin
		int               roll;
		logic [OPC_W-1:0] op;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		opcode   = OP_ALLOC;
		position = '0;
		handle   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pool rejects, unused opcode, swaps, hits and misses
		send_op(OP_FREE_POS, 8'd0, 8'd0);
		send_op(OP_FREE_HANDLE, 8'd0, 8'd0);
		send_op(OP_RESERVED, 8'hFF, 8'hFF);
		repeat (5) send_op(OP_ALLOC, 8'h00, 8'hFF);
		send_op(OP_FREE_POS, 8'hFF, 8'h00);
		send_op(OP_FREE_POS, 8'd4, 8'h00);
		send_op(OP_FREE_POS, 8'd0, 8'hFF);
		send_op(OP_FREE_HANDLE, 8'hFF, 8'd2);
		send_op(OP_FREE_HANDLE, 8'h00, 8'hFF);
		send_op(OP_FREE_HANDLE, 8'h00, 8'd4);
		repeat (2) send_op(OP_ALLOC, 8'hAA, 8'h55);
		send_op(OP_FREE_HANDLE, 8'h00, 8'd1);
		send_op(OP_FREE_HANDLE, 8'h00, 8'd3);
		send_op(OP_RESERVED, 8'h00, 8'h00);
		send_op(OP_FREE_POS, 8'd0, 8'h00);

		// Random: two fill phases drive the pool to full, then a drain phase
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 85;
				end
				1: begin
					tx_idle_pct = 85;
					rx_idle_pct = 13;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					pressure_on = 1'b1;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (ph < 2) begin
					op = (roll < 94) ? OP_ALLOC : (roll < 96) ? OP_FREE_POS :
						(roll < 99) ? OP_FREE_HANDLE : OP_RESERVED;
				end else begin
					op = (roll < 20) ? OP_ALLOC : (roll < 55) ? OP_FREE_POS :
						(roll < 97) ? OP_FREE_HANDLE : OP_RESERVED;
				end
				send_op(op, POS_W'($urandom_range(0, 255)), HDL_W'($urandom_range(0, 255)));
			end
		end
		in_valid = 1'b0;

		// Drain what is still owed, then watch for stray results
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Run: %0d operations with fill, full-pool and drain phases, %0d results checked,",
			ops_sent, results_seen);
		$display("     pool reported full %0d times, %0d mismatches", full_seen, mismatches);
		if (mismatches == 0) begin
			$display("dense_pool_slot_allocator test passed");
		end else begin
			$display("dense_pool_slot_allocator test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dpsa_pkg.sv
sv/dpsa_slot_ram.sv
sv/dpsa_ctrl.sv
sv/dpsa_out_reg.sv
sv/dense_pool_slot_allocator.sv
tb/sv/pool_checker.sv
tb/sv/testbench.sv
